### design/co2_sensor_uart_frame_exchange_top_macros.svh
// Assertion macros for the CO2 sensor UART frame exchange block.
// Used by co2ufx_engine.sv in this folder; expects clk and arst_n in scope.
`ifndef CO2_SENSOR_UART_FRAME_EXCHANGE_TOP_MACROS_SVH
`define CO2_SENSOR_UART_FRAME_EXCHANGE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked only while out of reset
`define CO2UFX_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("co2ufx assertion failed");
// Checked at every edge, reset included
`define CO2UFX_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("co2ufx assertion failed");
`else
`define CO2UFX_ASSERT(lbl, prop)
`define CO2UFX_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### design/co2ufx_pkg.sv
// Package for the CO2 sensor UART frame exchange: item types, codes, frame constants.
// No dependencies; used by every module of the block.
`default_nettype none

package co2ufx_pkg;

	// Frame geometry
	localparam int FrameBytes = 9;
	localparam int PosW       = $clog2(FrameBytes + 1);

	// Event codes
	localparam logic [1:0] CmdStart  = 2'd0;
	localparam logic [1:0] CmdTxDone = 2'd1;
	localparam logic [1:0] CmdRxByte = 2'd2;

	// Fixed command frame bytes
	localparam logic [7:0] SyncByte    = 8'hFF;
	localparam logic [7:0] SensorAddr  = 8'h01;
	localparam logic [7:0] ReadCmd     = 8'h86;
	localparam logic [7:0] CmdChecksum = 8'h79;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] rx_byte;
	} evt_item_t;

	typedef struct packed {
		logic        send_valid;
		logic [7:0]  send_byte;
		logic [15:0] co2_reading;
		logic [31:0] measure_count;
	} res_item_t;

	// Byte of the read-concentration command at a given position
	function automatic logic [7:0] cmd_byte(input logic [PosW-1:0] pos);
		logic [7:0] b;
		if (pos == '0) begin
			b = SyncByte;
		end else if (pos == PosW'(FrameBytes - 1)) begin
			b = CmdChecksum;
		end else if (pos == PosW'(1)) begin
			b = SensorAddr;
		end else if (pos == PosW'(2)) begin
			b = ReadCmd;
		end else begin
			b = 8'h00;
		end
		return b;
	endfunction

endpackage

`default_nettype wire

### design/co2_sensor_uart_frame_exchange_top.sv
// Top level of the CO2 sensor UART read-frame exchange.
// Depends on co2ufx_pkg, co2ufx_in_reg, co2ufx_engine, co2ufx_out_reg.
//
//   channel  signals                    item
//   event    evt_valid, evt_stall, evt  co2ufx_pkg::evt_item_t (command, rx_byte)
//   result   res_valid, res_stall, res  co2ufx_pkg::res_item_t (send, reading, count)
//
// One event item per cycle while evt_stall is low; res_valid rises as the item
// moves from the input register (loaded on acceptance) to the result register once free.
// The exchange state lives in the engine and updates as an item moves into the
// result register, so results come out in order.
// arst_n clears the counters, the reading and the good-frame count.
// A stalled result holds the held event; evt_stall rises only then.
`default_nettype none

module co2_sensor_uart_frame_exchange_top (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        evt_valid,
	output logic                       evt_stall,
	input  wire co2ufx_pkg::evt_item_t evt,
	output logic                       res_valid,
	input  wire                        res_stall,
	output co2ufx_pkg::res_item_t      res
);

	logic                  advance;
	logic                  valid_s1;
	logic                  fire;
	co2ufx_pkg::evt_item_t item_s1;
	co2ufx_pkg::res_item_t result;

	assign fire = valid_s1 && advance;

	co2ufx_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	co2ufx_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item_s1 (item_s1),
		.result  (result)
	);

	co2ufx_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.result    (result),
		.advance   (advance),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

`default_nettype wire

### design/co2ufx_in_reg.sv
// Input register stage of the CO2 frame exchange: holds one event item.
// Depends on co2ufx_pkg.
`default_nettype none

module co2ufx_in_reg (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        evt_valid,
	output logic                       evt_stall,
	input  wire co2ufx_pkg::evt_item_t evt,
	input  wire                        advance,
	output logic                       valid_s1,
	output co2ufx_pkg::evt_item_t      item_s1
);

	logic load;

	// Hold off the source only while a held item cannot move on
	assign evt_stall = valid_s1 && !advance;
	assign load      = evt_valid && !evt_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= evt;
		end
	end

endmodule

`default_nettype wire

### design/co2ufx_engine.sv
// Exchange engine: transmit/receive counters, running checksum, reading and count.
// Depends on co2ufx_pkg and the block's assertion macro header.
`default_nettype none
`include "co2_sensor_uart_frame_exchange_top_macros.svh"

module co2ufx_engine (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        fire,
	input  wire co2ufx_pkg::evt_item_t item_s1,
	output co2ufx_pkg::res_item_t      result
);

	localparam int PosW = co2ufx_pkg::PosW;
	localparam int FB   = co2ufx_pkg::FrameBytes;

	logic [PosW-1:0] tx_pos_q, tx_pos_d;
	logic [PosW-1:0] tx_rem_q, tx_rem_d;
	logic [PosW-1:0] rx_pos_q, rx_pos_d;
	logic [PosW-1:0] rx_rem_q, rx_rem_d;
	logic [7:0]      sum_q, sum_d;
	logic [7:0]      hi_q, hi_d;
	logic [7:0]      lo_q, lo_d;
	logic [15:0]     reading_q, reading_d;
	logic [31:0]     count_q, count_d;
	logic            send_valid;
	logic [7:0]      send_byte;
	logic [PosW-1:0] tx_next_pos;
	logic            check_ok;

	assign tx_next_pos = tx_pos_q + PosW'(1);
	// Last byte must equal the negated sum of the payload bytes
	assign check_ok    = (item_s1.rx_byte == 8'(~sum_q + 8'd1));

	// Next state and result for the held item
	always_comb begin
		tx_pos_d   = tx_pos_q;
		tx_rem_d   = tx_rem_q;
		rx_pos_d   = rx_pos_q;
		rx_rem_d   = rx_rem_q;
		sum_d      = sum_q;
		hi_d       = hi_q;
		lo_d       = lo_q;
		reading_d  = reading_q;
		count_d    = count_q;
		send_valid = 1'b0;
		send_byte  = 8'h00;
		case (item_s1.command)
			co2ufx_pkg::CmdStart: begin
				tx_pos_d   = '0;
				tx_rem_d   = PosW'(FB - 1);
				send_valid = 1'b1;
				send_byte  = co2ufx_pkg::cmd_byte('0);
			end
			co2ufx_pkg::CmdTxDone: begin
				if (tx_rem_q != '0) begin
					tx_rem_d   = tx_rem_q - PosW'(1);
					tx_pos_d   = tx_next_pos;
					send_valid = 1'b1;
					send_byte  = co2ufx_pkg::cmd_byte(tx_next_pos);
				end else begin
					// command sent: arm reception
					rx_pos_d = '0;
					rx_rem_d = PosW'(FB);
				end
			end
			co2ufx_pkg::CmdRxByte: begin
				if (rx_rem_q != '0) begin
					if (rx_pos_q == '0 && item_s1.rx_byte != co2ufx_pkg::SyncByte) begin
						rx_rem_d = '0;
					end else if (rx_pos_q < PosW'(FB)) begin
						rx_pos_d = rx_pos_q + PosW'(1);
						rx_rem_d = rx_rem_q - PosW'(1);
						if (rx_pos_q == '0) begin
							sum_d = 8'h00;
						end else if (rx_pos_q <= PosW'(FB - 2)) begin
							sum_d = sum_q + item_s1.rx_byte;
						end
						if (rx_pos_q == PosW'(2)) begin
							hi_d = item_s1.rx_byte;
						end
						if (rx_pos_q == PosW'(3)) begin
							lo_d = item_s1.rx_byte;
						end
						// last byte of the frame: verify
						if (rx_rem_q == PosW'(1) && check_ok) begin
							reading_d = {hi_d, lo_d};
							count_d   = count_q + 32'd1;
						end
					end else begin
						rx_rem_d = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign result.send_valid    = send_valid;
	assign result.send_byte     = send_byte;
	assign result.co2_reading   = reading_d;
	assign result.measure_count = count_d;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_pos_q  <= '0;
			tx_rem_q  <= '0;
			rx_pos_q  <= '0;
			rx_rem_q  <= '0;
			reading_q <= '0;
			count_q   <= '0;
		end else if (fire) begin
			tx_pos_q  <= tx_pos_d;
			tx_rem_q  <= tx_rem_d;
			rx_pos_q  <= rx_pos_d;
			rx_rem_q  <= rx_rem_d;
			reading_q <= reading_d;
			count_q   <= count_d;
		end
	end

	// Frame payload; written before it is read within each reception
	always_ff @(posedge clk) begin
		if (fire) begin
			sum_q <= sum_d;
			hi_q  <= hi_d;
			lo_q  <= lo_d;
		end
	end

	`CO2UFX_ASSERT(a_rx_span, rx_rem_q != '0 |-> ((PosW+1)'(rx_pos_q) + (PosW+1)'(rx_rem_q) == (PosW+1)'(FB)))
	`CO2UFX_ASSERT(a_tx_span, tx_rem_q != '0 |-> ((PosW+1)'(tx_pos_q) + (PosW+1)'(tx_rem_q) == (PosW+1)'(FB - 1)))
	`CO2UFX_ASSERT(a_count_step, count_q != $past(count_q) |-> count_q == $past(count_q) + 32'd1)
	`CO2UFX_ASSERT_ALWAYS(a_rem_bound, !arst_n || (tx_rem_q <= PosW'(FB - 1) && rx_rem_q <= PosW'(FB)))

endmodule

`default_nettype wire

### design/co2ufx_out_reg.sv
// Result register stage of the CO2 frame exchange: holds one result item.
// Depends on co2ufx_pkg.
`default_nettype none

module co2ufx_out_reg (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        fire,
	input  wire co2ufx_pkg::res_item_t result,
	output logic                       advance,
	output logic                       res_valid,
	input  wire                        res_stall,
	output co2ufx_pkg::res_item_t      res
);

	// Register may take a new item when empty or being drained
	assign advance = !res_valid || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res <= result;
		end
	end

endmodule

`default_nettype wire
